// ----- rtl/bdq_pkg.sv -----
// Shared constants and types for the bounded deque with search.
`default_nettype none
package bdq_pkg;

   localparam int CAPACITY = 32;
   localparam int PTR_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WORD_W   = 32;
   localparam int POS_W    = 5;
   localparam int FILL_W   = 6;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT,
      OP_PUSH_REAR,
      OP_DELETE,
      OP_FIND
   } op_type;

   typedef enum logic [2:0] {
      ST_PUSHED,
      ST_FOUND,
      ST_NOT_FOUND,
      ST_FULL,
      ST_EMPTY
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/bounded_deque_with_search.sv -----
// Bounded deque of 32-bit words with find and delete-first-match, store in one memory.
// Find and delete scan one entry per cycle; a delete then moves each later entry forward
// one per cycle. One item in work at a time: the next transfer comes the cycle after the
// result is registered.
// Reset clears head pointer, fill count and control; store contents stay undefined.
`default_nettype none
module bounded_deque_with_search (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  bdq_pkg::op_type             req_op,
   input  wire signed [31:0]           req_value,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output bdq_pkg::status_type         rsp_status,
   output logic [4:0]                  rsp_position,
   output logic [5:0]                  rsp_fill_count
);
   import bdq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_FIN
   } state_type;

   state_type               state_ff;
   logic [PTR_W-1:0]        head_ff;
   logic [CNT_W-1:0]        count_ff;
   op_type                  op_ff;
   logic [WORD_W-1:0]       key_ff;
   logic [CNT_W-1:0]        rd_pos_ff;
   logic                    cmp_vld_ff;
   logic [PTR_W-1:0]        cmp_pos_ff;
   logic [PTR_W-1:0]        wr_pos_ff;
   logic                    wr_pend_ff;
   status_type              res_status_ff;
   logic [POS_W-1:0]        res_pos_ff;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   logic [POS_W-1:0]        rsp_position_ff;
   logic [FILL_W-1:0]       rsp_fill_count_ff;

   logic [WORD_W-1:0]       store_mem [CAPACITY];
   logic [WORD_W-1:0]       mem_q_ff;
   logic [PTR_W-1:0]        mem_raddr;
   logic                    mem_we;
   logic [PTR_W-1:0]        mem_waddr;
   logic [WORD_W-1:0]       mem_wdata;

   logic                    full;
   logic                    found;

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign found     = cmp_vld_ff && (mem_q_ff == key_ff);
   assign mem_raddr = head_ff + rd_pos_ff[PTR_W-1:0];
   assign req_stall = (state_ff != S_IDLE);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_position   = rsp_position_ff;
   assign rsp_fill_count = rsp_fill_count_ff;

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = head_ff + wr_pos_ff;
      mem_wdata = mem_q_ff;
      if (state_ff == S_IDLE && req_valid && !full) begin
         if (req_op == OP_PUSH_FRONT) begin
            mem_we    = 1'b1;
            mem_waddr = head_ff - PTR_W'(1);
            mem_wdata = req_value;
         end else if (req_op == OP_PUSH_REAR) begin
            mem_we    = 1'b1;
            mem_waddr = head_ff + count_ff[PTR_W-1:0];
            mem_wdata = req_value;
         end
      end else if (state_ff == S_SHIFT && wr_pend_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= store_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         wr_pend_ff   <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff      <= req_op;
                  key_ff     <= req_value;
                  rd_pos_ff  <= '0;
                  cmp_vld_ff <= 1'b0;
                  wr_pend_ff <= 1'b0;
                  res_pos_ff <= '0;
                  unique case (req_op)
                     OP_PUSH_FRONT, OP_PUSH_REAR: begin
                        if (full) begin
                           res_status_ff <= ST_FULL;
                        end else begin
                           if (req_op == OP_PUSH_FRONT) begin
                              head_ff <= head_ff - PTR_W'(1);
                           end
                           count_ff      <= count_ff + CNT_W'(1);
                           res_status_ff <= ST_PUSHED;
                        end
                        state_ff <= S_FIN;
                     end
                     OP_DELETE, OP_FIND: begin
                        if (count_ff == '0) begin
                           res_status_ff <= (req_op == OP_DELETE) ? ST_EMPTY : ST_NOT_FOUND;
                           state_ff      <= S_FIN;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                  endcase
               end
            end
            S_SCAN: begin
               priority if (found) begin
                  cmp_vld_ff    <= 1'b0;
                  res_status_ff <= ST_FOUND;
                  res_pos_ff    <= POS_W'(cmp_pos_ff);
                  if (op_ff == OP_DELETE) begin
                     rd_pos_ff  <= CNT_W'(cmp_pos_ff) + CNT_W'(1);
                     wr_pend_ff <= 1'b0;
                     state_ff   <= S_SHIFT;
                  end else begin
                     state_ff <= S_FIN;
                  end
               end else if (rd_pos_ff < count_ff) begin
                  cmp_vld_ff <= 1'b1;
                  cmp_pos_ff <= rd_pos_ff[PTR_W-1:0];
                  rd_pos_ff  <= rd_pos_ff + CNT_W'(1);
               end else if (cmp_vld_ff) begin
                  cmp_vld_ff <= 1'b0;
               end else begin
                  res_status_ff <= ST_NOT_FOUND;
                  state_ff      <= S_FIN;
               end
            end
            S_SHIFT: begin
               if (rd_pos_ff < count_ff) begin
                  wr_pend_ff <= 1'b1;
                  wr_pos_ff  <= rd_pos_ff[PTR_W-1:0] - PTR_W'(1);
                  rd_pos_ff  <= rd_pos_ff + CNT_W'(1);
               end else begin
                  wr_pend_ff <= 1'b0;
                  if (!wr_pend_ff) begin
                     count_ff <= count_ff - CNT_W'(1);
                     state_ff <= S_FIN;
                  end
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_status_ff     <= res_status_ff;
                  rsp_position_ff   <= res_pos_ff;
                  rsp_fill_count_ff <= FILL_W'(count_ff);
                  state_ff          <= S_IDLE;
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire
